[rtl/cpt_pkg.sv]
// Shared types and constants of the capture pattern tokenizer.
package cpt_pkg;

    localparam int BYTE_W  = 8;
    localparam int REG_W   = 16;
    localparam int TOTAL_W = 16;
    localparam int BCNT_W  = 17;
    localparam int INDEX_W = 2;

    // Special pattern characters.
    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_MAX_BYTES    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_MAX_TOKENS   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MAX_CAPTURES = 2'd2;

    localparam logic [REG_W-1:0] RST_MAX_BYTES    = 16'd4096;
    localparam logic [REG_W-1:0] RST_MAX_TOKENS   = 16'd256;
    localparam logic [REG_W-1:0] RST_MAX_CAPTURES = 16'd64;

    // Token kinds.
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_FIELD   = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    // Final status codes.
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_BAD_LENGTH = 3'd1;
    localparam logic [2:0] STAT_TRAIL_ESC  = 3'd2;
    localparam logic [2:0] STAT_UNCLOSED   = 3'd3;
    localparam logic [2:0] STAT_LIMIT      = 3'd4;
    localparam logic [2:0] STAT_NO_CAPTURE = 3'd5;

    typedef struct packed {
        logic [REG_W-1:0] max_pattern_bytes;
        logic [REG_W-1:0] max_tokens;
        logic [REG_W-1:0] max_captures;
    } cpt_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic [1:0]         token_kind;
        logic               token_start;
        logic               done_res;
        logic [2:0]         status;
        logic [TOTAL_W-1:0] token_total;
        logic [TOTAL_W-1:0] capture_total;
        logic [TOTAL_W-1:0] slash_total;
    } cpt_result_t;

endpackage

[rtl/cpt_lexer.sv]
// Pattern lexer: mode state, counters, error tracking and per-byte result.
module cpt_lexer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [cpt_pkg::BYTE_W-1:0] pattern_byte,
    input  logic                      is_last,
    input  cpt_pkg::cpt_cfg_t         cfg,
    output logic                      produce,
    output cpt_pkg::cpt_result_t      result
);
    import cpt_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_OPEN,
        MODE_NAME
    } lex_mode_t;

    lex_mode_t              mode_reg, mode_next;
    logic                   in_lit_reg, in_lit_next;
    logic [BCNT_W-1:0]      bcnt_reg, bcnt_next;
    logic [COUNT_WIDTH-1:0] tok_reg, tok_next;
    logic [COUNT_WIDTH-1:0] cap_reg, cap_next;
    logic [COUNT_WIDTH-1:0] slash_reg, slash_next;
    logic [2:0]             err_reg, err_next;

    logic                   bad_len;
    logic                   held;
    logic                   lit;
    logic                   ovf;
    logic                   close_tok;
    logic                   over_limit;
    logic [CMP_W-1:0]       tok_ext, cap_ext, slash_ext;

    always_comb
    begin
        mode_next   = mode_reg;
        in_lit_next = in_lit_reg;
        tok_next    = tok_reg;
        cap_next    = cap_reg;
        slash_next  = slash_reg;
        err_next    = err_reg;
        lit         = 1'b0;
        ovf         = 1'b0;
        close_tok   = 1'b0;
        result      = '0;

        // The byte count saturates once it reaches 2^16.
        bcnt_next = bcnt_reg[BCNT_W-1] ? bcnt_reg : bcnt_reg + 1'b1;
        bad_len   = bcnt_next > {1'b0, cfg.max_pattern_bytes};
        held      = (err_reg != STAT_OK) || bad_len;
        if ((err_reg == STAT_OK) && bad_len)
        begin
            err_next = STAT_BAD_LENGTH;
        end

        if (!held)
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    if (pattern_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (pattern_byte == CH_PERCENT)
                    begin
                        in_lit_next = 1'b0;
                        mode_next   = MODE_OPEN;
                    end
                    else
                    begin
                        lit = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_NORMAL;
                    lit       = 1'b1;
                end
                MODE_OPEN:
                begin
                    if (pattern_byte == CH_PERCENT)
                    begin
                        result.token_kind  = KIND_DISCARD;
                        result.token_start = 1'b1;
                        mode_next          = MODE_NORMAL;
                        close_tok          = 1'b1;
                        if (&tok_reg)
                        begin
                            ovf = 1'b1;
                        end
                        else
                        begin
                            tok_next = tok_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next          = MODE_NAME;
                        result.out_byte    = pattern_byte;
                        result.byte_valid  = 1'b1;
                        result.token_kind  = KIND_FIELD;
                        result.token_start = 1'b1;
                    end
                end
                MODE_NAME:
                begin
                    if (pattern_byte == CH_PERCENT)
                    begin
                        mode_next = MODE_NORMAL;
                        close_tok = 1'b1;
                        if (&tok_reg)
                        begin
                            ovf = 1'b1;
                        end
                        else
                        begin
                            tok_next = tok_reg + 1'b1;
                        end
                        if (&cap_reg)
                        begin
                            ovf = 1'b1;
                        end
                        else
                        begin
                            cap_next = cap_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        result.out_byte   = pattern_byte;
                        result.byte_valid = 1'b1;
                        result.token_kind = KIND_FIELD;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase

            if (lit)
            begin
                if (!in_lit_reg)
                begin
                    in_lit_next        = 1'b1;
                    result.token_start = 1'b1;
                    if (&tok_reg)
                    begin
                        err_next = STAT_LIMIT;
                    end
                    else
                    begin
                        tok_next = tok_reg + 1'b1;
                    end
                end
                result.out_byte   = pattern_byte;
                result.byte_valid = 1'b1;
                result.token_kind = KIND_LITERAL;
                if ((pattern_byte == CH_SLASH) && !(&slash_reg))
                begin
                    slash_next = slash_reg + 1'b1;
                end
            end
        end

        tok_ext    = CMP_W'(tok_next);
        cap_ext    = CMP_W'(cap_next);
        slash_ext  = CMP_W'(slash_next);
        over_limit = (tok_ext > CMP_W'(cfg.max_tokens))
                  || (cap_ext > CMP_W'(cfg.max_captures));

        // Limits are tested when a discard or field token completes.
        if (close_tok && (ovf || over_limit))
        begin
            err_next = STAT_LIMIT;
        end

        if (is_last)
        begin
            result.done_res = 1'b1;
            if (bad_len)
            begin
                result.status = STAT_BAD_LENGTH;
            end
            else if (err_next != STAT_OK)
            begin
                result.status = err_next;
            end
            else if (mode_next == MODE_ESC)
            begin
                result.status = STAT_TRAIL_ESC;
            end
            else if ((mode_next == MODE_OPEN) || (mode_next == MODE_NAME))
            begin
                result.status = STAT_UNCLOSED;
            end
            else if (tok_ext > CMP_W'(cfg.max_tokens))
            begin
                result.status = STAT_LIMIT;
            end
            else if (cap_next == '0)
            begin
                result.status = STAT_NO_CAPTURE;
            end
            else
            begin
                result.status = STAT_OK;
            end
        end

        result.token_total   = tok_ext[TOTAL_W-1:0];
        result.capture_total = cap_ext[TOTAL_W-1:0];
        result.slash_total   = slash_ext[TOTAL_W-1:0];
        produce = !held || is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            in_lit_reg <= 1'b0;
            bcnt_reg   <= '0;
            tok_reg    <= '0;
            cap_reg    <= '0;
            slash_reg  <= '0;
            err_reg    <= STAT_OK;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                // A new pattern starts from the reset state.
                mode_reg   <= MODE_NORMAL;
                in_lit_reg <= 1'b0;
                bcnt_reg   <= '0;
                tok_reg    <= '0;
                cap_reg    <= '0;
                slash_reg  <= '0;
                err_reg    <= STAT_OK;
            end
            else
            begin
                mode_reg   <= mode_next;
                in_lit_reg <= in_lit_next;
                bcnt_reg   <= bcnt_next;
                tok_reg    <= tok_next;
                cap_reg    <= cap_next;
                slash_reg  <= slash_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule

[rtl/cpt_res_stage.sv]
// Result register stage with valid/ready handshake toward the consumer.
module cpt_res_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  cpt_pkg::cpt_result_t load_data,
    input  logic                 res_ready,
    output logic                 res_valid,
    output logic                 can_load,
    output cpt_pkg::cpt_result_t res_data
);
    import cpt_pkg::*;

    logic        valid_reg;
    cpt_result_t data_reg;

    assign can_load  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

[rtl/capture_pattern_tokenizer.sv]
// Capture pattern tokenizer: splits pattern bytes into literal, field and discard tokens.
// Latency: a result appears in the cycle after its request is accepted (one register stage).
// Throughput: one request per cycle while the consumer takes results; the result register
// is the only buffer, so the request side stalls only while a result waits unread.
// Bytes past an error or past the byte limit produce no result, except the last byte of a pattern.
// Reset (rst_n low, asynchronous) clears all pattern state and the result valid, and loads
// the limit registers with 4096 bytes, 256 tokens and 64 captures.
module capture_pattern_tokenizer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [cpt_pkg::BYTE_W-1:0]    pattern_byte,
    input  logic                          is_last,
    // Result channel.
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [cpt_pkg::BYTE_W-1:0]    out_byte,
    output logic                          byte_valid,
    output logic [1:0]                    token_kind,
    output logic                          token_start,
    output logic                          done_res,
    output logic [2:0]                    status,
    output logic [cpt_pkg::TOTAL_W-1:0]   token_total,
    output logic [cpt_pkg::TOTAL_W-1:0]   capture_total,
    output logic [cpt_pkg::TOTAL_W-1:0]   slash_total,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [cpt_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [cpt_pkg::REG_W-1:0]     cfg_data
);
    import cpt_pkg::*;

    cpt_cfg_t    cfg_reg;
    logic        accept;
    logic        produce;
    cpt_result_t lex_result;
    cpt_result_t res_data;

    // Limit registers. Writes to an index past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_pattern_bytes <= RST_MAX_BYTES;
            cfg_reg.max_tokens        <= RST_MAX_TOKENS;
            cfg_reg.max_captures      <= RST_MAX_CAPTURES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_BYTES:    cfg_reg.max_pattern_bytes <= cfg_data;
                REG_MAX_TOKENS:   cfg_reg.max_tokens        <= cfg_data;
                REG_MAX_CAPTURES: cfg_reg.max_captures      <= cfg_data;
                default:          cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // A request is taken whenever the result register is free or is being emptied
    // in the same cycle, so a full-rate consumer sees one result per cycle.
    assign accept = req_valid && req_ready;

    // The lexer updates its state on each accepted request and computes the result
    // combinationally from the request and the current state.
    cpt_lexer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pattern_byte (pattern_byte),
        .is_last      (is_last),
        .cfg          (cfg_reg),
        .produce      (produce),
        .result       (lex_result)
    );

    // Suppressed bytes load an empty slot, so no result is shown for them.
    cpt_res_stage u_res_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && produce),
        .load_data (lex_result),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .can_load  (req_ready),
        .res_data  (res_data)
    );

    assign out_byte      = res_data.out_byte;
    assign byte_valid    = res_data.byte_valid;
    assign token_kind    = res_data.token_kind;
    assign token_start   = res_data.token_start;
    assign done_res      = res_data.done_res;
    assign status        = res_data.status;
    assign token_total   = res_data.token_total;
    assign capture_total = res_data.capture_total;
    assign slash_total   = res_data.slash_total;

endmodule

[rtl/cpt_checker.sv]
// Port-level checks of the tokenizer result channel, bound to the top level.
module cpt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [cpt_pkg::BYTE_W-1:0]  out_byte,
    input logic                        byte_valid,
    input logic                        done_res,
    input logic [2:0]                  status,
    input logic [cpt_pkg::TOTAL_W-1:0] token_total,
    input logic [cpt_pkg::TOTAL_W-1:0] capture_total
);
    import cpt_pkg::*;

    // A stalled result holds its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(status)
            && $stable(token_total) && $stable(done_res))
        else $error("result changed while stalled");

    // Status is only reported on the result for the last byte.
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !done_res |-> status == STAT_OK)
        else $error("status reported before the end of the pattern");

    // A result without token text carries a zero byte.
    a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !byte_valid |-> out_byte == '0)
        else $error("text byte set on a result without text");

    // A pattern that ends clean has at least one capture.
    a_ok_capture: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res && status == STAT_OK |-> capture_total != '0)
        else $error("clean pattern reported without a capture");

endmodule

bind capture_pattern_tokenizer cpt_checker u_cpt_checker (.*);
